FILE: src/m4inv_pkg.sv
// shared types and constants for the 4x4 adjugate matrix inverse
`timescale 1ns / 1ps
`default_nettype none

package m4inv_pkg;

  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int NUM_ELEMS         = 16;
  localparam int IDX_W             = 4;
  localparam int OUT_W             = 32;
  localparam int DET_W             = 64;

  // write request from the loader into the matrix queue
  typedef struct packed {
    logic             we;
    logic             commit;
    logic [IDX_W-1:0] idx;
  } load_wr_t;

  // one result beat
  typedef struct packed {
    logic [OUT_W-1:0] inverse_element;
    logic [DET_W-1:0] determinant;
    logic             singular;
    logic             last;
  } result_t;

  // back end sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIAG_START,
    ST_MUL_SETUP,
    ST_MUL,
    ST_MUL_END,
    ST_COF,
    ST_CHECK,
    ST_SING,
    ST_DOUT,
    ST_DIV_START,
    ST_DIV,
    ST_DIV_OUT
  } back_state_e;

endpackage

`default_nettype wire

FILE: src/m4inv_front.sv
// loader: takes element beats and places them in the free matrix slot
`timescale 1ns / 1ps
`default_nettype none

module m4inv_front #(
  parameter int ELEMENT_WIDTH = m4inv_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [m4inv_pkg::OUT_W-1:0] element_i,
  input  logic                      slot_free_i,
  output m4inv_pkg::load_wr_t       wr_o,
  output logic [ELEMENT_WIDTH-1:0]  wr_data_o
);
  import m4inv_pkg::*;

  logic             accept;
  logic [IDX_W-1:0] load_count_q;

  // a beat is taken only while a slot is free to write into
  assign full   = ~slot_free_i;
  assign accept = push & slot_free_i;

  // element position within the matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
    end else if (accept) begin
      load_count_q <= load_count_q + IDX_W'(1);
    end
  end

  // write request, the sixteenth element commits the slot
  always_comb begin
    wr_o.we     = accept;
    wr_o.idx    = load_count_q;
    wr_o.commit = accept && (load_count_q == IDX_W'(NUM_ELEMS - 1));
  end

  assign wr_data_o = element_i[ELEMENT_WIDTH-1:0];

endmodule

`default_nettype wire

FILE: src/m4inv_mqueue.sv
// two-slot matrix queue between loader and solver
`timescale 1ns / 1ps
`default_nettype none

module m4inv_mqueue #(
  parameter int ELEMENT_WIDTH = m4inv_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  m4inv_pkg::load_wr_t              wr_i,
  input  logic [ELEMENT_WIDTH-1:0]         wr_data_i,
  output logic                             slot_free_o,
  output logic                             valid_o,
  input  logic                             release_i,
  input  logic [m4inv_pkg::IDX_W-1:0]      rd_idx_i,
  output logic [ELEMENT_WIDTH-1:0]         rd_data_o
);
  import m4inv_pkg::*;

  logic [ELEMENT_WIDTH-1:0] slot_q [2*NUM_ELEMS];
  logic                     wr_ptr_q;
  logic                     rd_ptr_q;
  logic [1:0]               cnt_q;

  assign slot_free_o = (cnt_q != 2'd2);
  assign valid_o     = (cnt_q != 2'd0);

  // element storage, written by the loader
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      slot_q[{wr_ptr_q, wr_i.idx}] <= wr_data_i;
    end
  end

  // head slot read by the solver
  assign rd_data_o = slot_q[{rd_ptr_q, rd_idx_i}];

  // slot pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_i.commit) wr_ptr_q <= ~wr_ptr_q;
      if (release_i)   rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(wr_i.commit) - 2'(release_i);
    end
  end

endmodule

`default_nettype wire

FILE: src/m4inv_back.sv
// solver: cofactors, determinant and per-entry long division
`timescale 1ns / 1ps
`default_nettype none

module m4inv_back #(
  parameter int ELEMENT_WIDTH = m4inv_pkg::ELEMENT_WIDTH_DEF,
  parameter int FRACTION_BITS = m4inv_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        mat_valid_i,
  output logic                        mat_release_o,
  output logic [m4inv_pkg::IDX_W-1:0] rd_idx_o,
  input  logic [ELEMENT_WIDTH-1:0]    rd_data_i,
  input  logic                        res_full_i,
  output logic                        res_push_o,
  output m4inv_pkg::result_t          res_o
);
  import m4inv_pkg::*;

  localparam int EW = ELEMENT_WIDTH;
  localparam int MW = 3 * EW + 1;                // signed minor / cofactor
  localparam int ML = (MW + EW - 1) / EW;        // limbs of a multiplicand
  localparam int LW = $clog2(ML);
  localparam int XW = ML * EW;
  localparam int PW = XW + EW;                   // product magnitude
  localparam int DW = 4 * EW + 3;                // signed determinant
  localparam int NW = MW + 2 * FRACTION_BITS;    // scaled numerator
  localparam int SW = DW + EW;
  localparam int CW = (NW > SW) ? NW : SW;
  localparam int RW = DW + 1;
  localparam int BW = $clog2(EW);
  localparam int SH = (4 * FRACTION_BITS > DET_W / 2) ? 4 * FRACTION_BITS - DET_W / 2 : 0;
  localparam int TW = (DW > DET_W + 1) ? DW : DET_W + 1;

  // column used by diagonal d on minor row r
  function automatic logic [1:0] col_of(input logic [2:0] d, input logic [1:0] r);
    logic [2:0] s;
    if (d < 3'd3) begin
      s = d + 3'(r);
    end else begin
      s = d - 3'(r);
    end
    if (s >= 3'd3) s = s - 3'd3;
    return s[1:0];
  endfunction

  back_state_e state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [2:0]       d_q, d_d;
  logic [1:0]       r_q, r_d;
  logic [LW-1:0]    k_q, k_d;
  logic [BW-1:0]    b_q, b_d;
  logic             det_mode_q, det_mode_d;

  logic [XW-1:0]        xs_q;
  logic [EW-1:0]        em_q;
  logic                 psign_q;
  logic [PW-1:0]        acc_q;
  logic signed [MW-1:0] minor_q;
  logic signed [DW-1:0] det_q;
  logic signed [MW-1:0] adj_q [NUM_ELEMS];
  logic [DW-1:0]        dmag_q;
  logic                 dneg_q;
  logic [DET_W-1:0]     dout_q;
  logic [RW-1:0]        rem_q;
  logic [EW-1:0]        numlo_q;
  logic [EW-1:0]        quo_q;
  logic                 qneg_q;
  logic                 ovf_q;

  logic [1:0]           xr, xc, r_sel, c_sel, rr, cc;
  logic                 e_neg;
  logic [EW-1:0]        e_mag;
  logic [EW-1:0]        limb;
  logic [2*EW-1:0]      pp;
  logic [PW-1:0]        acc_next;
  logic [MW-1:0]        acc_m;
  logic [DW-1:0]        acc_d;
  logic signed [MW-1:0] cof;
  logic [MW-1:0]        cof_mag;
  logic signed [MW-1:0] a_sel;
  logic [MW-1:0]        a_mag;
  logic [CW-1:0]        num;
  logic                 num_ovf;
  logic [RW-1:0]        rem2;
  logic                 rem_ge;
  logic [TW-1:0]        t_det, t_lim, t_sat;
  logic [EW-1:0]        q_lim, q_sat, q_val;

  assign xr = i_q[3:2];
  assign xc = i_q[1:0];

  // element address: one element of the current diagonal, or row 0 for the determinant
  always_comb begin
    r_sel = (state_q == ST_DIAG_START) ? 2'd0 : r_q;
    c_sel = col_of(d_q, r_sel);
    rr    = r_sel + 2'(r_sel >= xr);
    cc    = c_sel + 2'(c_sel >= xc);
    if (state_q == ST_COF) begin
      rd_idx_o = {xc, 2'b00};
    end else begin
      rd_idx_o = {cc, rr};
    end
  end

  assign e_neg = rd_data_i[EW-1];
  assign e_mag = e_neg ? (~rd_data_i + EW'(1)) : rd_data_i;

  // one limb times one element magnitude per cycle, most significant limb first
  assign limb     = xs_q[k_q*EW +: EW];
  assign pp       = limb * em_q;
  assign acc_next = (acc_q << EW) + PW'(pp);
  assign acc_m    = psign_q ? (~acc_q[MW-1:0] + MW'(1)) : acc_q[MW-1:0];
  assign acc_d    = psign_q ? (~acc_q[DW-1:0] + DW'(1)) : acc_q[DW-1:0];

  // checkerboard sign on the finished minor
  assign cof     = (xr[0] ^ xc[0]) ? -minor_q : minor_q;
  assign cof_mag = cof[MW-1] ? MW'(-cof) : MW'(cof);

  // numerator setup and overflow test against the quotient range
  assign a_sel   = adj_q[i_q];
  assign a_mag   = a_sel[MW-1] ? MW'(-a_sel) : MW'(a_sel);
  assign num     = CW'(a_mag) << (2 * FRACTION_BITS);
  assign num_ovf = num >= (CW'(dmag_q) << EW);

  // restoring division step
  assign rem2   = {rem_q[RW-2:0], numlo_q[EW-1]};
  assign rem_ge = rem2 >= RW'(dmag_q);

  // determinant scaled to Q32.32 and saturated
  assign t_det = TW'(dmag_q >> SH);
  assign t_lim = TW'({dneg_q, {(DET_W - 1){~dneg_q}}});
  assign t_sat = (t_det > t_lim) ? t_lim : t_det;

  // quotient saturation
  assign q_lim = {qneg_q, {(EW - 1){~qneg_q}}};
  assign q_sat = (ovf_q || (quo_q > q_lim)) ? q_lim : quo_q;
  assign q_val = qneg_q ? (~q_sat + EW'(1)) : q_sat;

  // next state, counters and result beats
  always_comb begin
    state_d       = state_q;
    i_d           = i_q;
    d_d           = d_q;
    r_d           = r_q;
    k_d           = k_q;
    b_d           = b_q;
    det_mode_d    = det_mode_q;
    mat_release_o = 1'b0;
    res_push_o    = 1'b0;
    res_o         = '0;
    case (state_q)
      ST_IDLE: begin
        if (mat_valid_i) begin
          i_d     = '0;
          d_d     = '0;
          state_d = ST_DIAG_START;
        end
      end
      ST_DIAG_START: begin
        r_d     = 2'd1;
        state_d = ST_MUL_SETUP;
      end
      ST_MUL_SETUP: begin
        k_d     = LW'(r_q - 2'd1);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (k_q == '0) begin
          state_d = ST_MUL_END;
        end else begin
          k_d = k_q - LW'(1);
        end
      end
      ST_MUL_END: begin
        if (det_mode_q) begin
          det_mode_d = 1'b0;
          d_d        = '0;
          i_d        = i_q + IDX_W'(1);
          state_d    = ST_DIAG_START;
        end else if (r_q == 2'd2) begin
          if (d_q == 3'd5) begin
            state_d = ST_COF;
          end else begin
            d_d     = d_q + 3'd1;
            state_d = ST_DIAG_START;
          end
        end else begin
          r_d     = 2'd2;
          state_d = ST_MUL_SETUP;
        end
      end
      ST_COF: begin
        if (xr == 2'd0) begin
          det_mode_d = 1'b1;
          k_d        = LW'(ML - 1);
          state_d    = ST_MUL;
        end else if (i_q == IDX_W'(NUM_ELEMS - 1)) begin
          state_d = ST_CHECK;
        end else begin
          d_d     = '0;
          i_d     = i_q + IDX_W'(1);
          state_d = ST_DIAG_START;
        end
      end
      ST_CHECK: begin
        mat_release_o = 1'b1;
        state_d       = (det_q == '0) ? ST_SING : ST_DOUT;
      end
      ST_SING: begin
        if (!res_full_i) begin
          res_push_o   = 1'b1;
          res_o.singular = 1'b1;
          res_o.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_DOUT: begin
        i_d     = '0;
        state_d = ST_DIV_START;
      end
      ST_DIV_START: begin
        b_d     = BW'(EW - 1);
        state_d = num_ovf ? ST_DIV_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (b_q == '0) begin
          state_d = ST_DIV_OUT;
        end else begin
          b_d = b_q - BW'(1);
        end
      end
      ST_DIV_OUT: begin
        if (!res_full_i) begin
          res_push_o            = 1'b1;
          res_o.inverse_element = OUT_W'(signed'(q_val));
          res_o.determinant     = dout_q;
          res_o.last            = (i_q == IDX_W'(NUM_ELEMS - 1));
          if (i_q == IDX_W'(NUM_ELEMS - 1)) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = ST_DIV_START;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      i_q        <= '0;
      d_q        <= '0;
      r_q        <= '0;
      k_q        <= '0;
      b_q        <= '0;
      det_mode_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      d_q        <= d_d;
      r_q        <= r_d;
      k_q        <= k_d;
      b_q        <= b_d;
      det_mode_q <= det_mode_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        minor_q <= '0;
        det_q   <= '0;
      end
      ST_DIAG_START: begin
        xs_q    <= XW'(e_mag);
        psign_q <= e_neg ^ (d_q >= 3'd3);
      end
      ST_MUL_SETUP: begin
        em_q    <= e_mag;
        psign_q <= psign_q ^ e_neg;
        acc_q   <= '0;
      end
      ST_MUL: begin
        acc_q <= acc_next;
      end
      ST_MUL_END: begin
        if (det_mode_q) begin
          det_q   <= det_q + signed'(acc_d);
          minor_q <= '0;
        end else if (r_q == 2'd2) begin
          minor_q <= minor_q + signed'(acc_m);
        end else begin
          xs_q <= acc_q[XW-1:0];
        end
      end
      ST_COF: begin
        adj_q[i_q] <= cof;
        xs_q       <= XW'(cof_mag);
        em_q       <= e_mag;
        psign_q    <= cof[MW-1] ^ e_neg;
        acc_q      <= '0;
        if (xr != 2'd0) minor_q <= '0;
      end
      ST_CHECK: begin
        dneg_q <= det_q[DW-1];
        dmag_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      end
      ST_DOUT: begin
        dout_q <= dneg_q ? (~t_sat[DET_W-1:0] + DET_W'(1)) : t_sat[DET_W-1:0];
      end
      ST_DIV_START: begin
        rem_q   <= RW'(num >> EW);
        numlo_q <= num[EW-1:0];
        qneg_q  <= a_sel[MW-1] ^ dneg_q;
        ovf_q   <= num_ovf;
        quo_q   <= '0;
      end
      ST_DIV: begin
        rem_q   <= rem_ge ? (rem2 - RW'(dmag_q)) : rem2;
        quo_q   <= {quo_q[EW-2:0], rem_ge};
        numlo_q <= numlo_q << 1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/m4inv_ofifo.sv
// two-entry result queue toward the consumer
`timescale 1ns / 1ps
`default_nettype none

module m4inv_ofifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  m4inv_pkg::result_t data_i,
  output logic               full_o,
  input  logic               pop,
  output logic               empty,
  output m4inv_pkg::result_t data_o
);
  import m4inv_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o = (cnt_q == 2'd2);
  assign empty  = (cnt_q == 2'd0);
  assign do_pop = pop & ~empty;
  assign data_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

FILE: src/matrix4_inverse_adjugate.sv
// 4x4 matrix inverse by adjugate, fixed point, queue-style ports
//
// Input: sixteen element beats per matrix, column-major, signed Q16.16 in
// the low ELEMENT_WIDTH bits. A beat is taken when push is high and full is
// low. Beats may follow back to back; a second matrix may be loaded while the
// previous one is being solved, full rises only when both slots are taken.
// Output: a result beat waits on the ports while empty is low and leaves
// when pop is high. A regular matrix gives 16 inverse entries (column-major,
// saturated) with the Q32.32 determinant, last on the sixteenth; a zero
// determinant gives one beat with singular and last set.
// Solving: after its last element each matrix goes through 16 cofactors on
// one 32x32 limb multiplier (six diagonals of three elements, plus four
// determinant terms) and then 16 restoring divisions at one quotient bit per
// cycle; a division is skipped when its quotient would overflow. The first
// result beat is pushed once the first division is done.
// Reset: asynchronous, clears load position, queues and sequencer; partial
// matrices are dropped. A stalled consumer fills the two-entry result queue
// and then holds the solver; loading continues until both slots are full.
`timescale 1ns / 1ps
`default_nettype none

module matrix4_inverse_adjugate #(
  parameter int ELEMENT_WIDTH = m4inv_pkg::ELEMENT_WIDTH_DEF,
  parameter int FRACTION_BITS = m4inv_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [m4inv_pkg::OUT_W-1:0]   element_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [m4inv_pkg::OUT_W-1:0]   inverse_element_o,
  output logic [m4inv_pkg::DET_W-1:0]   determinant_o,
  output logic                          singular_o,
  output logic                          last_o
);
  import m4inv_pkg::*;

  load_wr_t                 wr;
  logic [ELEMENT_WIDTH-1:0] wr_data;
  logic                     slot_free;
  logic                     mat_valid;
  logic                     mat_release;
  logic [IDX_W-1:0]         rd_idx;
  logic [ELEMENT_WIDTH-1:0] rd_data;
  logic                     res_full;
  logic                     res_push;
  result_t                  res;
  result_t                  head;

  // loader
  m4inv_front #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .element_i  (element_i),
    .slot_free_i(slot_free),
    .wr_o       (wr),
    .wr_data_o  (wr_data)
  );

  // matrix slots
  m4inv_mqueue #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_mqueue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .wr_data_i  (wr_data),
    .slot_free_o(slot_free),
    .valid_o    (mat_valid),
    .release_i  (mat_release),
    .rd_idx_i   (rd_idx),
    .rd_data_o  (rd_data)
  );

  // solver
  m4inv_back #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mat_valid_i  (mat_valid),
    .mat_release_o(mat_release),
    .rd_idx_o     (rd_idx),
    .rd_data_i    (rd_data),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // result queue
  m4inv_ofifo u_ofifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(res_push),
    .data_i(res),
    .full_o(res_full),
    .pop   (pop),
    .empty (empty),
    .data_o(head)
  );

  assign inverse_element_o = head.inverse_element;
  assign determinant_o     = head.determinant;
  assign singular_o        = head.singular;
  assign last_o            = head.last;

  // a singular beat always closes its run
  a_singular_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && singular_o) |-> last_o)
    else $error("singular beat without last");

  // the solver frees only a slot that holds a matrix
  a_release_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mat_release |-> mat_valid)
    else $error("matrix slot released while none is held");

  // the solver never writes into a full result queue
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result beat pushed into full queue");

  // a committed matrix is visible to the solver on the next cycle
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.commit |=> mat_valid)
    else $error("committed matrix not seen by solver");

endmodule

`default_nettype wire
